// ===== design/sma_pkg.sv =====
// Shared types and constants for the stack machine arithmetic block.
// Used by the shared adder, the stack RAM wrapper and the top level.
package sma_pkg;

    // Field widths fixed by the interface
    localparam int OP_W     = 3;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;

    // Divider iteration count and its counter width
    localparam int DIV_STEPS = DATA_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // Opcodes; codes 6 and 7 act as nop
    typedef enum logic [OP_W-1:0] {
        OP_NOP  = 3'd0,
        OP_SWAP = 3'd1,
        OP_ADD  = 3'd2,
        OP_SUB  = 3'd3,
        OP_DIV  = 3'd4,
        OP_PUSH = 3'd5
    } t_op;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_SHORT   = 2'd1,
        ST_DIVZERO = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    // Request to the shared adder: a + b, or a - b when sub is set
    typedef struct packed {
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic              sub;
    } t_alu_req;

endpackage

// ===== design/sma_alu.sv =====
// Shared 32-bit add/subtract unit with carry out.
// Serves add, sub, operand and quotient negation and every restoring-divide step.
// Depends on sma_pkg.
module sma_alu (
    input  sma_pkg::t_alu_req          i_req,
    output logic [sma_pkg::DATA_W:0]   o_sum
);
    import sma_pkg::*;

    // On subtract the carry out is set when a >= b (unsigned)
    assign o_sum = {1'b0, i_req.a}
                 + {1'b0, i_req.b ^ {DATA_W{i_req.sub}}}
                 + {{DATA_W{1'b0}}, i_req.sub};

endmodule

// ===== design/sma_stack_ram.sv =====
// Stack storage: one write port and one read port with registered read data.
// Depends on sma_pkg for the data width.
module sma_stack_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [AW-1:0]              i_waddr,
    input  logic [sma_pkg::DATA_W-1:0] i_wdata,
    input  logic                       i_re,
    input  logic [AW-1:0]              i_raddr,
    output logic [sma_pkg::DATA_W-1:0] o_rdata
);
    import sma_pkg::*;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/stack_machine_arith_ops_top.sv =====
// Stack machine arithmetic block: sequencer, stack count and top-of-stack cache.
// Instantiates sma_alu and sma_stack_ram; depends on sma_pkg.
//
//  Channel  Dir  Handshake                 Payload
//  s_axis   in   i_s_tvalid / o_s_tready   tuser: op; tdata: push_value
//  m_axis   out  o_m_tvalid / i_m_tready   tuser: status; tdata: top_value, stack_count
//
// Per item: nop, push and any error go straight to done; add and sub pass read and exec; swap also passes swap2;
// div passes read, exec, two negations, 32 restoring steps and a final negation in the shared adder.
// One item at a time; o_s_tready is high only while the sequencer is idle.
// A held result stalls the sequencer in its done state until the output register frees.
// Synchronous active-low reset clears the count; stack RAM contents are not cleared.
module stack_machine_arith_ops_top #(
    parameter int STACK_DEPTH = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // Input stream
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [sma_pkg::DATA_W-1:0]          i_s_tdata,  // [31:0] push_value
    input  logic [sma_pkg::OP_W-1:0]            i_s_tuser,  // [2:0] op
    // Output stream
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [((sma_pkg::DATA_W + $clog2(STACK_DEPTH + 1) + 7) / 8) * 8 - 1:0]
                                                o_m_tdata,  // [31:0] top_value,
                                                            // then stack_count, zero fill
    output logic [sma_pkg::STATUS_W-1:0]        o_m_tuser   // [1:0] status
);
    import sma_pkg::*;

    localparam int CW    = $clog2(STACK_DEPTH + 1);
    localparam int AW    = $clog2(STACK_DEPTH);
    localparam int OUT_W = ((DATA_W + CW + 7) / 8) * 8;
    localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);
    localparam logic [CW-1:0] C_ONE   = CW'(1);
    localparam logic [CW-1:0] C_TWO   = CW'(2);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_READ  = 9'b000000010,
        S_EXEC  = 9'b000000100,
        S_SWAP2 = 9'b000001000,
        S_NEGA  = 9'b000010000,
        S_NEGB  = 9'b000100000,
        S_DIV   = 9'b001000000,
        S_NEGQ  = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

    t_state               r_state, n_state;
    logic [CW-1:0]        r_count, n_count;
    logic [DATA_W-1:0]    r_top, n_top;
    logic [DATA_W-1:0]    r_a, n_a;
    logic [DATA_W-1:0]    r_b, n_b;
    logic [DATA_W-1:0]    r_rem, n_rem;
    logic [STEP_W-1:0]    r_step, n_step;
    logic                 r_sign, n_sign;
    logic [OP_W-1:0]      r_op, n_op;
    logic [STATUS_W-1:0]  r_status, n_status;

    // Output register
    logic                 r_ov;
    logic [STATUS_W-1:0]  r_out_status;
    logic [DATA_W-1:0]    r_out_top;
    logic [CW-1:0]        r_out_count;
    logic                 out_load;

    // RAM and adder hookup
    logic                 we, re;
    logic [AW-1:0]        waddr, raddr;
    logic [DATA_W-1:0]    wdata, rd_data;
    t_alu_req             alu_req;
    logic [DATA_W:0]      alu_sum;

    logic [CW-1:0]        cm1, cm2;
    logic [DATA_W-1:0]    div_t;
    logic [DATA_W-1:0]    quot;

    assign cm1   = r_count - C_ONE;
    assign cm2   = r_count - C_TWO;
    assign div_t = {r_rem[DATA_W-2:0], r_a[DATA_W-1]};
    assign quot  = r_sign ? alu_sum[DATA_W-1:0] : r_a;

    sma_alu u_alu (
        .i_req (alu_req),
        .o_sum (alu_sum)
    );

    sma_stack_ram #(
        .DEPTH (STACK_DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rd_data)
    );

    assign o_s_tready = (r_state == S_IDLE);
    assign out_load   = (r_state == S_DONE) && (!r_ov || i_m_tready);

    // Sequencer
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_top    = r_top;
        n_a      = r_a;
        n_b      = r_b;
        n_rem    = r_rem;
        n_step   = r_step;
        n_sign   = r_sign;
        n_op     = r_op;
        n_status = r_status;
        we       = 1'b0;
        waddr    = cm2[AW-1:0];
        wdata    = r_b;
        re       = 1'b0;
        raddr    = cm2[AW-1:0];
        alu_req  = '{a: r_a, b: r_b, sub: 1'b0};

        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_op     = i_s_tuser;
                    n_status = ST_OK;
                    n_state  = S_DONE;
                    if (i_s_tuser inside {OP_SWAP, OP_ADD, OP_SUB, OP_DIV}) begin
                        if (r_count < C_TWO) begin
                            n_status = ST_SHORT;
                        end else if (i_s_tuser == OP_DIV && r_top == '0) begin
                            n_status = ST_DIVZERO;
                        end else begin
                            // fetch the second entry; top lives in r_top
                            re      = 1'b1;
                            n_state = S_READ;
                        end
                    end else if (i_s_tuser == OP_PUSH) begin
                        if (r_count >= DEPTH_C) begin
                            n_status = ST_FULL;
                        end else begin
                            we      = 1'b1;
                            waddr   = r_count[AW-1:0];
                            wdata   = i_s_tdata;
                            n_top   = i_s_tdata;
                            n_count = r_count + C_ONE;
                        end
                    end
                end
            end
            S_READ: begin
                n_a     = rd_data;
                n_b     = r_top;
                n_state = S_EXEC;
            end
            S_EXEC: begin
                case (r_op)
                    OP_SWAP: begin
                        we      = 1'b1;
                        waddr   = cm1[AW-1:0];
                        wdata   = r_a;
                        n_top   = r_a;
                        n_state = S_SWAP2;
                    end
                    OP_ADD, OP_SUB: begin
                        alu_req = '{a: r_a, b: r_b, sub: (r_op == OP_SUB)};
                        we      = 1'b1;
                        wdata   = alu_sum[DATA_W-1:0];
                        n_top   = alu_sum[DATA_W-1:0];
                        n_count = cm1;
                        n_state = S_DONE;
                    end
                    OP_DIV: begin
                        n_sign  = r_a[DATA_W-1] ^ r_b[DATA_W-1];
                        n_state = S_NEGA;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_SWAP2: begin
                // old top goes one below
                we      = 1'b1;
                wdata   = r_b;
                n_state = S_DONE;
            end
            S_NEGA: begin
                // dividend magnitude
                alu_req = '{a: '0, b: r_a, sub: 1'b1};
                if (r_a[DATA_W-1]) begin
                    n_a = alu_sum[DATA_W-1:0];
                end
                n_state = S_NEGB;
            end
            S_NEGB: begin
                // divisor magnitude
                alu_req = '{a: '0, b: r_b, sub: 1'b1};
                if (r_b[DATA_W-1]) begin
                    n_b = alu_sum[DATA_W-1:0];
                end
                n_rem   = '0;
                n_step  = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                // one restoring step: quotient bits shift into r_a
                alu_req = '{a: div_t, b: r_b, sub: 1'b1};
                n_rem   = alu_sum[DATA_W] ? alu_sum[DATA_W-1:0] : div_t;
                n_a     = {r_a[DATA_W-2:0], alu_sum[DATA_W]};
                n_step  = r_step + STEP_W'(1);
                if (r_step == LAST_STEP) begin
                    n_state = S_NEGQ;
                end
            end
            S_NEGQ: begin
                // apply quotient sign and write back
                alu_req = '{a: '0, b: r_a, sub: 1'b1};
                we      = 1'b1;
                wdata   = quot;
                n_top   = quot;
                n_count = cm1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_ov || i_m_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (i_m_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_top    <= n_top;
        r_a      <= n_a;
        r_b      <= n_b;
        r_rem    <= n_rem;
        r_step   <= n_step;
        r_sign   <= n_sign;
        r_op     <= n_op;
        r_status <= n_status;
        if (out_load) begin
            r_out_status <= r_status;
            r_out_top    <= (r_count != '0) ? r_top : '0;
            r_out_count  <= r_count;
        end
    end

    // Output transfer
    assign o_m_tvalid = r_ov;
    assign o_m_tuser  = r_out_status;
    assign o_m_tdata  = OUT_W'({r_out_count, r_out_top});

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for stack_machine_arith_ops_top: directed corner cases, then random
// push/op streams with idling on both streams. Depends on sma_pkg and the design sources.
module testbench;
    import sma_pkg::*;

    localparam int STACK_DEPTH = 64;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int TDATA_W     = ((DATA_W + CNT_W + 7) / 8) * 8;
    localparam int RAND_ITEMS  = 900;
    localparam int CALM_ITEMS  = 100;

    // Spare opcodes, decoded as nop
    localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;

    typedef struct {
        t_status           status;
        logic [DATA_W-1:0] top;
        logic [CNT_W-1:0]  count;
    } t_stack_result;

    typedef enum int {FEED_FILL, FEED_DRAIN, FEED_ANY, FEED_TOPOFF} t_feed_mode;

    // Mirror of the stack plus the queue of results still to arrive
    class stack_scoreboard;
        logic [DATA_W-1:0] slots [STACK_DEPTH];
        int unsigned       depth_now;
        t_stack_result     due_results [$];
        int unsigned       fail_count;

        function new();
            depth_now  = 0;
            fail_count = 0;
        endfunction

        function int unsigned pending();
            return due_results.size();
        endfunction

        // Apply one accepted op to the mirror and queue its result
        function void note_input(logic [OP_W-1:0] op, logic [DATA_W-1:0] val);
            t_stack_result     res;
            logic [DATA_W-1:0] top, sec, ma, mb, q;
            res.status = ST_OK;
            case (op)
                OP_SWAP, OP_ADD, OP_SUB, OP_DIV: begin
                    if (depth_now < 2) begin
                        res.status = ST_SHORT;
                    end else begin
                        top = slots[depth_now-1];
                        sec = slots[depth_now-2];
                        if (op == OP_SWAP) begin
                            slots[depth_now-1] = sec;
                            slots[depth_now-2] = top;
                        end else if (op == OP_DIV && top == '0) begin
                            res.status = ST_DIVZERO;
                        end else begin
                            if (op == OP_ADD) begin
                                slots[depth_now-2] = sec + top;
                            end else if (op == OP_SUB) begin
                                slots[depth_now-2] = sec - top;
                            end else begin
                                // truncate toward zero on magnitudes; min / -1 wraps
                                ma = sec[DATA_W-1] ? -sec : sec;
                                mb = top[DATA_W-1] ? -top : top;
                                q  = ma / mb;
                                slots[depth_now-2] = (sec[DATA_W-1] ^ top[DATA_W-1]) ? -q : q;
                            end
                            depth_now--;
                        end
                    end
                end
                OP_PUSH: begin
                    if (depth_now >= STACK_DEPTH) begin
                        res.status = ST_FULL;
                    end else begin
                        slots[depth_now] = val;
                        depth_now++;
                    end
                end
                default: ;
            endcase
            res.top   = (depth_now > 0) ? slots[depth_now-1] : '0;
            res.count = depth_now[CNT_W-1:0];
            due_results.push_back(res);
        endfunction

        // Compare one result transfer with the oldest prediction
        function void check_result(logic [STATUS_W-1:0] status, logic [TDATA_W-1:0] data);
            t_stack_result want;
            if (due_results.size() == 0) begin
                $error("result transfer with no prediction pending (status %0d)", status);
                fail_count++;
                return;
            end
            want = due_results.pop_front();
            if (status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, status);
                fail_count++;
            end
            if (data[DATA_W-1:0] !== want.top) begin
                $error("top_value: expected %0d, actual %0d",
                       $signed(want.top), $signed(data[DATA_W-1:0]));
                fail_count++;
            end
            if (data[DATA_W +: CNT_W] !== want.count) begin
                $error("stack_count: expected %0d, actual %0d", want.count, data[DATA_W +: CNT_W]);
                fail_count++;
            end
        endfunction
    endclass

    logic                i_clk      = 1'b0;
    logic                i_rst_n    = 1'b0;
    logic                i_s_tvalid = 1'b0;
    logic                o_s_tready;
    logic [DATA_W-1:0]   i_s_tdata  = '0;
    logic [OP_W-1:0]     i_s_tuser  = '0;
    logic                o_m_tvalid;
    logic                i_m_tready = 1'b0;
    logic [TDATA_W-1:0]  o_m_tdata;
    logic [STATUS_W-1:0] o_m_tuser;

    bit              quiet_tail = 1'b0;
    stack_scoreboard sb;

    stack_machine_arith_ops_top #(
        .STACK_DEPTH(STACK_DEPTH)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always #1 i_clk = ~i_clk;

    // Offer one op and hold it until the input transfer happens
    task automatic send_item(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] val);
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= val;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.note_input(op, val);
    endtask

    // Random input gaps, none in the tail
    task automatic pace_sender();
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    task automatic issue(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] val);
        send_item(op, val);
        pace_sender();
    endtask

    // Operand values biased toward the wrap and divide corners
    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'h0000_0001;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h8000_0000;
            4:       return 32'h7FFF_FFFF;
            5:       return $urandom_range(0, 31) - 16;
            default: return $urandom;
        endcase
    endfunction

    // Empty-stack errors, spare opcodes, wraps, zero divisor, truncation
    task automatic run_directed();
        issue(OP_NOP,    32'hFFFF_FFFF);
        issue(OP_SWAP,   32'h0);
        issue(OP_ADD,    32'h0);
        issue(OP_SUB,    32'h0);
        issue(OP_DIV,    32'h0);
        issue(OP_SPARE6, 32'hA5A5_A5A5);
        issue(OP_SPARE7, 32'h5A5A_5A5A);
        issue(OP_PUSH,   32'h7FFF_FFFF);
        issue(OP_ADD,    32'h0);          // one entry only
        issue(OP_PUSH,   32'h0000_0001);
        issue(OP_ADD,    32'h0);          // max + 1 wraps to min
        issue(OP_PUSH,   32'h0000_0001);
        issue(OP_SUB,    32'h0);          // min - 1 wraps to max
        issue(OP_PUSH,   32'h0000_0000);
        issue(OP_DIV,    32'h0);          // zero divisor, stack kept
        issue(OP_SWAP,   32'h0);
        issue(OP_DIV,    32'h0);          // 0 / max
        issue(OP_PUSH,   32'h8000_0000);
        issue(OP_PUSH,   32'hFFFF_FFFF);
        issue(OP_DIV,    32'h0);          // min / -1 wraps
        issue(OP_PUSH,   32'hFFFF_FFF9);
        issue(OP_PUSH,   32'h0000_0002);
        issue(OP_DIV,    32'h0);          // -7 / 2 truncates to -3
        issue(OP_SWAP,   32'h0);
        issue(OP_SUB,    32'h0);
    endtask

    // Random segments that fill, drain, mix or top off the stack
    task automatic run_random(input int unsigned total);
        t_feed_mode        mode;
        int unsigned       seg_left;
        logic [OP_W-1:0]   op;
        mode     = FEED_TOPOFF;
        seg_left = STACK_DEPTH - sb.depth_now + 3;
        for (int unsigned n = 0; n < total; n++) begin
            if (n >= total - CALM_ITEMS) quiet_tail = 1'b1;
            if (seg_left == 0) begin
                if ($urandom_range(0, 5) == 0) begin
                    mode     = FEED_TOPOFF;
                    seg_left = STACK_DEPTH - sb.depth_now + $urandom_range(1, 3);
                end else begin
                    case ($urandom_range(0, 2))
                        0:       mode = FEED_FILL;
                        1:       mode = FEED_DRAIN;
                        default: mode = FEED_ANY;
                    endcase
                    seg_left = $urandom_range(20, 60);
                end
            end
            case (mode)
                FEED_TOPOFF: op = OP_PUSH;
                FEED_FILL:   op = ($urandom_range(0, 9) < 8) ? OP_PUSH : 3'($urandom_range(0, 7));
                FEED_DRAIN:  op = ($urandom_range(0, 9) == 0) ? OP_PUSH : 3'($urandom_range(1, 4));
                default:     op = 3'($urandom_range(0, 7));
            endcase
            issue(op, pick_value());
            seg_left--;
        end
    endtask

    // Result sink: random stalls, one long hold-off to back up the input
    initial begin : result_sink
        int unsigned stall_left;
        int unsigned checked;
        bit          held;
        stall_left = 0;
        checked    = 0;
        held       = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready) begin
                sb.check_result(o_m_tuser, o_m_tdata);
                checked++;
            end
            if (!held && checked == 300) begin
                held       = 1'b1;
                stall_left = 250;
            end else if (stall_left == 0 && !quiet_tail && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 3);
            end
            if (stall_left > 0) begin
                i_m_tready <= 1'b0;
                stall_left--;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // Stimulus and end of run
    initial begin : stimulus
        sb = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        run_directed();
        run_random(RAND_ITEMS);
        i_s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (sb.fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog
    initial begin : watchdog
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
